@@ rtl/battery_average_and_soc_estimator_top_defines.svh @@
// Assertion macros used by the battery estimator checker file.
`ifndef BATTERY_AVERAGE_AND_SOC_ESTIMATOR_TOP_DEFINES_SVH
`define BATTERY_AVERAGE_AND_SOC_ESTIMATOR_TOP_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define BSOC_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is held.
`define BSOC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bsoc_pkg.sv @@
// Shared constants, codes and the discharge curve lookup of the battery estimator.
package bsoc_pkg;

    // Field widths.
    localparam int MV_W    = 13;
    localparam int PCT_W   = 7;
    localparam int CFG_IDX_W = 2;

    // Averaging window.
    localparam int WINDOW_LEN = 50;
    localparam int PTR_W      = $clog2(WINDOW_LEN);
    localparam int SUM_W      = $clog2(WINDOW_LEN * ((1 << MV_W) - 1) + 1);

    // Division by the window length as a multiply by a rounded-up reciprocal.
    // The extra eight bits of shift keep the quotient exact for every sum.
    localparam int DIV_SHIFT = SUM_W + 8;
    localparam int MULT_W    = DIV_SHIFT - $clog2(WINDOW_LEN) + 1;
    localparam longint unsigned DIV_MULT =
        ((64'd1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int PROD_W    = SUM_W + MULT_W;

    // Item function codes.
    typedef enum logic {
        FUNC_TICK     = 1'b0,
        FUNC_ESTIMATE = 1'b1
    } func_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_LOST_MV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USB_CHARGE_MV = 2'd2;

    // Configuration reset values.
    localparam logic [MV_W-1:0] FULL_MV_RST       = 13'd4150;
    localparam logic [MV_W-1:0] POWER_LOST_MV_RST = 13'd3300;
    localparam logic [MV_W-1:0] USB_CHARGE_MV_RST = 13'd4200;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Discharge curve, voltage falling along the table.
    localparam int TABLE_POINTS = 21;
    localparam logic [MV_W-1:0] CURVE_MV [TABLE_POINTS] = '{
        13'd4140, 13'd4104, 13'd4068, 13'd4032, 13'd3996, 13'd3960, 13'd3924,
        13'd3888, 13'd3852, 13'd3829, 13'd3808, 13'd3787, 13'd3766, 13'd3745,
        13'd3724, 13'd3703, 13'd3672, 13'd3570, 13'd3420, 13'd3220, 13'd3000
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [TABLE_POINTS] = '{
        7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
        7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
        7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
    };

    // Nearest curve point. Since the curve falls strictly, point i is at least as
    // close as point i+1 exactly when 2*mv reaches their sum, so the first point
    // that passes this test is the nearest one, the earlier one winning a tie.
    function automatic logic [PCT_W-1:0] soc_lookup(input logic [MV_W-1:0] mv);
        logic [MV_W:0]    twice;
        logic             found;
        logic [PCT_W-1:0] pct;
        twice = {mv, 1'b0};
        found = 1'b0;
        pct   = CURVE_PCT[TABLE_POINTS-1];
        for (int i = 0; i < TABLE_POINTS - 1; i++) begin
            if (!found && twice >= ({1'b0, CURVE_MV[i]} + {1'b0, CURVE_MV[i+1]})) begin
                found = 1'b1;
                pct   = CURVE_PCT[i];
            end
        end
        return pct;
    endfunction

endpackage

@@ rtl/bsoc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module bsoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/battery_average_and_soc_estimator_top.sv @@
// Battery voltage averaging window and state-of-charge estimator, top level.
//
// Input channel (s_valid/s_ready): one item per handshake. s_func selects a
// sample tick, which enters s_sample_mv into a sliding window of WINDOW_LEN
// samples, or an estimate request, which returns the charge percent for the
// instant sample or the window average (s_use_average).
// Result channel (m_valid/m_ready): exactly one result item per input item,
// in order, carrying the percent, the power-lost flag and the window average.
// Configuration channel (cfg_valid/cfg_ready): always ready; cfg_index picks
// the full, power-lost or USB-charge threshold; other indexes are ignored.
// A result passes through the input register, then the result register, before
// it is offered on the result channel.
// Throughput: one item per cycle while m_ready is high, set by the window RAM,
// whose read of the next slot is issued ahead of its use.
// When m_ready is low the result register holds and the input register still
// takes one more item; s_ready drops only when both registers are occupied.
// Reset clears the window pointer, fill flag, running sum, average and min-hold
// and restores the thresholds to their defaults; window RAM contents are masked
// until the first wrap, so no clearing pass is needed.
module battery_average_and_soc_estimator_top
    import bsoc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel.
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_func,
    input  logic [MV_W-1:0]      s_sample_mv,
    input  logic                 s_use_average,
    // Result channel.
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PCT_W-1:0]     m_soc_percent,
    output logic                 m_power_lost,
    output logic [MV_W-1:0]      m_avg_mv,
    output logic                 m_avg_valid,
    // Configuration channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MV_W-1:0]      cfg_data
);

    // Configuration registers.
    logic [MV_W-1:0] full_mv_reg;
    logic [MV_W-1:0] power_lost_mv_reg;
    logic [MV_W-1:0] usb_charge_mv_reg;

    // Input register.
    logic            in_valid_reg;
    func_t           in_func_reg;
    logic [MV_W-1:0] in_sample_reg;
    logic            in_use_avg_reg;

    // Block state.
    logic [PTR_W-1:0] wpos_reg,     wpos_next;
    logic             full_reg,     full_next;
    logic [SUM_W-1:0] sum_reg,      sum_next;
    logic [MV_W-1:0]  avg_reg,      avg_next;
    logic [MV_W-1:0]  held_reg,     held_next;

    // Result register.
    logic             out_valid_reg;
    logic [PCT_W-1:0] out_soc_reg,  out_soc_next;
    logic             out_plost_reg, out_plost_next;
    logic [MV_W-1:0]  out_avg_reg;
    logic             out_avg_valid_reg;

    // Datapath signals.
    logic             advance;
    logic             is_tick;
    logic [MV_W-1:0]  ram_rd_data;
    logic [MV_W-1:0]  old_sample;
    logic [PTR_W-1:0] rd_addr;
    logic             pos_last;
    logic [PROD_W-1:0] product;
    logic [MV_W-1:0]  volt;
    logic [MV_W-1:0]  held_clamped;

    // Pipeline handshake: the input register moves into the result register when
    // the result register is empty or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign is_tick   = (in_func_reg == FUNC_TICK);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_mv_reg       <= FULL_MV_RST;
            power_lost_mv_reg <= POWER_LOST_MV_RST;
            usb_charge_mv_reg <= USB_CHARGE_MV_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FULL_MV:       full_mv_reg       <= cfg_data;
                REG_POWER_LOST_MV: power_lost_mv_reg <= cfg_data;
                REG_USB_CHARGE_MV: usb_charge_mv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg    <= func_t'(s_func);
            in_sample_reg  <= s_sample_mv;
            in_use_avg_reg <= s_use_average;
        end
    end

    // Window RAM. The read address is the slot the pointer will hold after this
    // edge, so the registered read data always shows the slot under the pointer.
    assign rd_addr = wpos_next;

    bsoc_ram #(
        .WIDTH (MV_W),
        .DEPTH (WINDOW_LEN)
    ) u_window_ram (
        .aclk    (aclk),
        .wr_en   (advance && is_tick),
        .wr_addr (wpos_reg),
        .wr_data (in_sample_reg),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // Slots are filled in order, so a slot holds a written sample exactly once
    // the window has wrapped; before that it counts as zero.
    assign old_sample = full_reg ? ram_rd_data : '0;
    assign pos_last   = (wpos_reg == PTR_W'(WINDOW_LEN - 1));

    // Running sum divided by the window length.
    assign product = PROD_W'(sum_next) * PROD_W'(DIV_MULT);

    // Voltage chosen for an estimate, and the min-hold after the charge clamp.
    assign volt = (in_use_avg_reg && (avg_reg != '0)) ? avg_reg : in_sample_reg;
    assign held_clamped = (volt > usb_charge_mv_reg) ? usb_charge_mv_reg : held_reg;

    // Next state and result for the item in the input register.
    always_comb begin
        wpos_next      = wpos_reg;
        full_next      = full_reg;
        sum_next       = sum_reg;
        avg_next       = avg_reg;
        held_next      = held_reg;
        out_soc_next   = '0;
        if (advance && is_tick) begin
            sum_next  = sum_reg - SUM_W'(old_sample) + SUM_W'(in_sample_reg);
            wpos_next = pos_last ? '0 : wpos_reg + PTR_W'(1);
            full_next = full_reg || pos_last;
            if (full_next) begin
                avg_next = product[DIV_SHIFT +: MV_W];
            end
        end else if (advance) begin
            if (in_sample_reg > full_mv_reg) begin
                out_soc_next = PCT_FULL;
            end else begin
                if ((volt < held_clamped) || (held_clamped == '0)) begin
                    held_next = volt;
                end else begin
                    held_next = held_clamped;
                end
                out_soc_next = soc_lookup(held_next);
            end
        end
        out_plost_next = full_next && (avg_next < power_lost_mv_reg);
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg <= '0;
            full_reg <= 1'b0;
            sum_reg  <= '0;
            avg_reg  <= '0;
            held_reg <= '0;
        end else begin
            wpos_reg <= wpos_next;
            full_reg <= full_next;
            sum_reg  <= sum_next;
            avg_reg  <= avg_next;
            held_reg <= held_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_soc_reg       <= out_soc_next;
            out_plost_reg     <= out_plost_next;
            out_avg_reg       <= avg_next;
            out_avg_valid_reg <= full_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_soc_percent = out_soc_reg;
    assign m_power_lost  = out_plost_reg;
    assign m_avg_mv      = out_avg_reg;
    assign m_avg_valid   = out_avg_valid_reg;

endmodule

@@ rtl/bsoc_checker.sv @@
// Port-level checker for the battery estimator and its bind to the top level.
`include "battery_average_and_soc_estimator_top_defines.svh"

module bsoc_checker
    import bsoc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [PCT_W-1:0]     m_soc_percent,
    input logic                 m_power_lost,
    input logic [MV_W-1:0]      m_avg_mv,
    input logic                 m_avg_valid
);

    // Remembers that a delivered item has shown a filled window.
    logic seen_full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_full_reg <= 1'b0;
        end else if (m_valid && m_ready && m_avg_valid) begin
            seen_full_reg <= 1'b1;
        end
    end

    // No result item may be offered right after reset.
    `BSOC_ASSERT_ALWAYS(a_no_result_after_reset, aclk,
        !aresetn |=> !m_valid, "result item offered right after reset")

    // A stalled result item holds its fields.
    `BSOC_ASSERT_RST(a_result_held, aclk, aresetn,
        (m_valid && !m_ready) |=> (m_valid && $stable(m_soc_percent)
            && $stable(m_power_lost) && $stable(m_avg_mv) && $stable(m_avg_valid)),
        "stalled result item changed")

    // Once the window has filled it stays filled.
    `BSOC_ASSERT_RST(a_full_sticky, aclk, aresetn,
        (m_valid && seen_full_reg) |-> m_avg_valid, "window fill flag dropped")

    // Before the window fills there is no average and no power-lost flag.
    `BSOC_ASSERT_RST(a_unfilled_quiet, aclk, aresetn,
        (m_valid && !m_avg_valid) |-> ((m_avg_mv == '0) && !m_power_lost),
        "average or power-lost shown before window filled")

endmodule

bind battery_average_and_soc_estimator_top bsoc_checker u_bsoc_checker (.*);
